>>> hdl/mma_pkg.sv
// Shared widths, defaults and pipeline type for the multichannel moving average.
package mma_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int CH_W         = 3;
    localparam int AVG_W        = 16;

    localparam int DEF_CHANNELS = 8;
    localparam int DEF_WINDOW   = 4;

    // Beat held between the fetch stage and the divide stage.
    typedef struct packed {
        logic                valid;
        logic                in_range;
        logic                full;
        logic [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]     ch;
    } t_s1;

endpackage

>>> hdl/mma_in_if.sv
// Sample input channel: valid/ready handshake carrying a sample and its channel.
interface mma_in_if;
    import mma_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;
    logic [CH_W-1:0]     channel;

    modport source (output valid, output sample_value, output channel, input ready);
    modport sink   (input valid, input sample_value, input channel, output ready);
endinterface

>>> hdl/mma_out_if.sv
// Result channel: valid/ready handshake carrying an average and its channel.
interface mma_out_if;
    import mma_pkg::*;

    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] average;
    logic [CH_W-1:0]  channel_out;

    modport source (output valid, output average, output channel_out, input ready);
    modport sink   (input valid, input average, input channel_out, output ready);
endinterface

>>> hdl/multichannel_moving_average.sv
// Top level of the per-channel recursive moving average.
//
// Usage: samples enter on i_in (sample_value, channel) with a valid/ready
// handshake; one result beat per sample leaves on o_out (average,
// channel_out), in input order. Each channel keeps a ring of WINDOW samples
// and a 16-bit average updated as avg + (new - oldest) / WINDOW, with the
// quotient truncated toward zero and the sum wrapping modulo 65536.
// A channel number at or above CHANNELS changes no state and returns 0.
//
// Pipeline: three register stages (window RAM read, divide, accumulate into
// the result register); an accepted beat passes through them in that order.
// Throughput: one beat per cycle while o_out is not stalled, set by the single
// window RAM port pair and the accumulate loop on the per-channel average.
// Each stage fills whenever it is empty, so i_in keeps accepting while a
// finished result waits until the pipeline is full.
// Reset: i_rst_n clears all pointers, averages and valid flags at once; ring
// slots not yet written since reset read as zero, so no clearing pass is run.
// Receiver stall: o_out holds its beat and the stages behind it back up,
// then i_in.ready drops.
module multichannel_moving_average #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW   = mma_pkg::DEF_WINDOW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mma_in_if.sink       i_in,
    mma_out_if.source    o_out
);
    import mma_pkg::*;

    t_s1                 w_s1;
    logic [SAMPLE_W-1:0] w_oldest;
    logic                w_s1_ready;

    mma_fetch #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_fetch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_sample   (i_in.sample_value),
        .i_ch       (i_in.channel),
        .o_s1       (w_s1),
        .o_oldest   (w_oldest),
        .i_s1_ready (w_s1_ready)
    );

    mma_update #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_update (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1          (w_s1),
        .i_oldest      (w_oldest),
        .o_s1_ready    (w_s1_ready),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_average     (o_out.average),
        .o_channel_out (o_out.channel_out)
    );
endmodule

>>> hdl/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mma_ram #(
    parameter int WIDTH  = 10,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and write to the same address return the old word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/mma_fetch.sv
// Accept stage: ring pointer bookkeeping, window RAM write and oldest-sample read.
module mma_fetch #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW   = mma_pkg::DEF_WINDOW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mma_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [mma_pkg::CH_W-1:0]      i_ch,
    output mma_pkg::t_s1                  o_s1,
    output logic [mma_pkg::SAMPLE_W-1:0]  o_oldest,
    input  logic                          i_s1_ready
);
    import mma_pkg::*;

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CXW   = (CW > CH_W) ? CW : CH_W;
    localparam int PW    = $clog2(WINDOW);
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);

    logic [PW-1:0]       r_pos [CHANNELS];
    logic [CHANNELS-1:0] r_full;
    t_s1                 r_s1;
    t_s1                 n_s1;

    logic                en1;
    logic                accept;
    logic [CXW-1:0]      w_ch_x;
    logic [CW-1:0]       w_idx;
    logic                w_in_range;
    logic [PW-1:0]       w_pos;
    logic                w_last;
    logic [AW-1:0]       w_addr;
    logic [SAMPLE_W-1:0] w_rdata;

    assign en1        = !r_s1.valid || i_s1_ready;
    assign o_ready    = en1;
    assign accept     = i_valid && en1;

    assign w_ch_x     = CXW'(i_ch);
    assign w_idx      = w_ch_x[CW-1:0];
    assign w_in_range = int'(i_ch) < CHANNELS;
    assign w_pos      = r_pos[w_idx];
    assign w_last     = w_pos == PW'(WINDOW - 1);
    assign w_addr     = AW'(int'(w_idx) * WINDOW + int'(w_pos));

    always_comb begin
        n_s1.valid    = i_valid;
        n_s1.in_range = w_in_range;
        // Slot under the pointer holds real data only once the ring has wrapped.
        n_s1.full     = r_full[w_idx];
        n_s1.sample   = i_sample;
        n_s1.ch       = i_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_pos      <= '{default: '0};
            r_full     <= '0;
        end else begin
            if (en1) begin
                r_s1 <= n_s1;
            end
            if (accept && w_in_range) begin
                r_pos[w_idx] <= w_last ? '0 : w_pos + 1'b1;
                if (w_last) begin
                    r_full[w_idx] <= 1'b1;
                end
            end
        end
    end

    mma_ram #(
        .WIDTH  (SAMPLE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (accept && w_in_range),
        .i_waddr (w_addr),
        .i_wdata (i_sample),
        .i_re    (en1),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign o_s1     = r_s1;
    assign o_oldest = r_s1.full ? w_rdata : '0;
endmodule

>>> hdl/mma_update.sv
// Divide and accumulate stages plus the result register.
module mma_update #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW   = mma_pkg::DEF_WINDOW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mma_pkg::t_s1                  i_s1,
    input  logic [mma_pkg::SAMPLE_W-1:0]  i_oldest,
    output logic                          o_s1_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mma_pkg::AVG_W-1:0]     o_average,
    output logic [mma_pkg::CH_W-1:0]      o_channel_out
);
    import mma_pkg::*;

    localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CXW     = (CW > CH_W) ? CW : CH_W;
    // Exact truncating divide of a SAMPLE_W-bit magnitude: floor(x * RECIP / 2^SHIFT).
    localparam int SHIFT   = SAMPLE_W + $clog2(WINDOW);
    localparam int RECIP_W = SAMPLE_W + 2;
    localparam int PROD_W  = SAMPLE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << SHIFT) + WINDOW - 1) / WINDOW);

    typedef struct packed {
        logic                valid;
        logic                in_range;
        logic                neg;
        logic [SAMPLE_W-1:0] quot;
        logic [CH_W-1:0]     ch;
    } t_s2;

    t_s2                 r_s2;
    t_s2                 n_s2;
    logic [AVG_W-1:0]    r_avg [CHANNELS];
    logic                r_out_valid;
    logic [AVG_W-1:0]    r_average;
    logic [CH_W-1:0]     r_channel_out;
    logic [AVG_W-1:0]    n_avg;

    logic                en_out;
    logic                en2;
    logic [SAMPLE_W:0]   w_diff;
    logic                w_neg;
    logic [SAMPLE_W-1:0] w_mag;
    logic [PROD_W-1:0]   w_prod;
    logic [CXW-1:0]      w_ch_x;
    logic [CW-1:0]       w_idx;
    logic [AVG_W-1:0]    w_q16;
    logic [AVG_W-1:0]    w_qs;

    assign en_out     = !r_out_valid || i_ready;
    assign en2        = !r_s2.valid || en_out;
    assign o_s1_ready = en2;

    // Divide stage: sign-magnitude so the quotient truncates toward zero.
    assign w_diff = {1'b0, i_s1.sample} - {1'b0, i_oldest};
    assign w_neg  = w_diff[SAMPLE_W];
    assign w_mag  = w_neg ? (~w_diff[SAMPLE_W-1:0] + 1'b1) : w_diff[SAMPLE_W-1:0];
    assign w_prod = PROD_W'(w_mag) * PROD_W'(RECIP);

    always_comb begin
        n_s2.valid    = i_s1.valid;
        n_s2.in_range = i_s1.in_range;
        n_s2.neg      = w_neg;
        n_s2.quot     = SAMPLE_W'(w_prod >> SHIFT);
        n_s2.ch       = i_s1.ch;
    end

    // Accumulate stage: average read and written in the same stage, so
    // back-to-back beats on one channel see each other's updates.
    assign w_ch_x = CXW'(r_s2.ch);
    assign w_idx  = w_ch_x[CW-1:0];
    assign w_q16  = AVG_W'(r_s2.quot);
    assign w_qs   = r_s2.neg ? (~w_q16 + 1'b1) : w_q16;
    assign n_avg  = r_avg[w_idx] + w_qs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_avg       <= '{default: '0};
        end else begin
            if (en2) begin
                r_s2 <= n_s2;
            end
            if (en_out) begin
                r_out_valid <= r_s2.valid;
                if (r_s2.valid && r_s2.in_range) begin
                    r_avg[w_idx] <= n_avg;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_average     <= r_s2.in_range ? n_avg : '0;
            r_channel_out <= r_s2.ch;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_average     = r_average;
    assign o_channel_out = r_channel_out;
endmodule

>>> hdl/mma_checker.sv
// Port-level checks for the moving average block, attached by bind.
module mma_checker #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [mma_pkg::AVG_W-1:0]    i_average,
    input logic [mma_pkg::CH_W-1:0]     i_channel_out
);
    import mma_pkg::*;

    // Nothing comes out in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    // An empty result register lets the whole pipeline move, so input is open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while result register empty");

    // Unknown channel always reports a zero average.
    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (int'(i_channel_out) >= CHANNELS)) |-> (i_average == '0))
        else $error("nonzero average for channel beyond range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_average) && $stable(i_channel_out)))
        else $error("result beat changed while stalled");
endmodule

bind multichannel_moving_average mma_checker #(
    .CHANNELS (CHANNELS)
) u_mma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_average     (o_out.average),
    .i_channel_out (o_out.channel_out)
);

>>> tb/tb_top.sv
// Self-checking bench for the multichannel moving average: random traffic, in-order predictor.
module tb_top;
    import mma_pkg::*;

    localparam int NCH        = DEF_CHANNELS;
    localparam int NWIN       = DEF_WINDOW;
    localparam int RAND_ITEMS = 900;
    localparam int IDLE_PCT   = 34;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]     ch;
    } t_sample;

    typedef struct {
        logic [AVG_W-1:0] average;
        logic [CH_W-1:0]  ch;
    } t_avg;

    logic i_clk;
    logic i_rst_n;

    mma_in_if  in_if ();
    mma_out_if out_if ();

    multichannel_moving_average #(
        .CHANNELS (NCH),
        .WINDOW   (NWIN)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state
    logic [SAMPLE_W-1:0] win_mem [NCH][NWIN];
    int unsigned         ring_ptr [NCH];
    logic [AVG_W-1:0]    avg_reg [NCH];

    t_sample sample_q [$];
    t_avg    avg_q [$];

    int n_accepted;
    int n_results;
    int n_errors;
    int n_neg_steps;
    int n_wraps;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic t_avg next_average(t_sample s);
        t_avg             r;
        int               diff;
        int               quot;
        int unsigned      pos;
        logic [AVG_W-1:0] upd;
        r.ch = s.ch;
        if (s.ch >= NCH) begin
            r.average = '0;
            return r;
        end
        pos  = ring_ptr[s.ch];
        diff = int'(s.sample) - int'(win_mem[s.ch][pos]);
        quot = diff / NWIN;   // truncates toward zero
        upd  = avg_reg[s.ch] + AVG_W'(quot);
        if (quot < 0) begin
            n_neg_steps++;
            if (upd > avg_reg[s.ch])
                n_wraps++;
        end
        avg_reg[s.ch]      = upd;
        win_mem[s.ch][pos] = s.sample;
        ring_ptr[s.ch]     = (pos + 1 == NWIN) ? 0 : pos + 1;
        r.average = upd;
        return r;
    endfunction

    function automatic bit take_gap(int count);
        // long stretch with the handshake running flat out
        if (count >= 350 && count < 550)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin : drive
            bit hold;
            hold = in_if.valid && !in_if.ready;
            if (in_if.valid && in_if.ready) begin
                avg_q.push_back(next_average(sample_q[0]));
                void'(sample_q.pop_front());
                n_accepted++;
            end
            if (!hold) begin
                if (sample_q.size() > 0 && !take_gap(n_accepted)) begin
                    in_if.valid        <= 1'b1;
                    in_if.sample_value <= sample_q[0].sample;
                    in_if.channel      <= sample_q[0].ch;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin : watch
            t_avg want;
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (avg_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected beat: expected none, got average %0d ch %0d",
                             $time, out_if.average, out_if.channel_out);
                end else begin
                    want = avg_q.pop_front();
                    if (out_if.average !== want.average) begin
                        n_errors++;
                        $display("%0t: average mismatch ch %0d: expected %0d, got %0d",
                                 $time, want.ch, want.average, out_if.average);
                    end
                    if (out_if.channel_out !== want.ch) begin
                        n_errors++;
                        $display("%0t: channel mismatch: expected %0d, got %0d",
                                 $time, want.ch, out_if.channel_out);
                    end
                end
            end
            out_if.ready <= !take_gap(n_results);
        end
    end

    task automatic queue_sample(int unsigned value, int unsigned ch);
        t_sample s;
        s.sample = SAMPLE_W'(value);
        s.ch     = CH_W'(ch);
        sample_q.push_back(s);
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.sample_value = '0;
        in_if.channel      = '0;
        out_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        n_accepted         = 0;
        n_results          = 0;
        n_errors           = 0;
        n_neg_steps        = 0;
        n_wraps            = 0;
        for (int c = 0; c < NCH; c++) begin
            ring_ptr[c] = 0;
            avg_reg[c]  = '0;
            for (int w = 0; w < NWIN; w++)
                win_mem[c][w] = '0;
        end

        // startup ramp to full scale, then full-scale drops back to zero
        repeat (5) queue_sample(1023, 0);
        repeat (5) queue_sample(0, 0);
        // truncation drift: small gains round to nothing, the drop costs one,
        // so the average wraps below zero
        repeat (4) queue_sample(3, 1);
        repeat (4) queue_sample(6, 1);
        queue_sample(0, 1);
        queue_sample(512, 2);
        queue_sample(1, 3);
        queue_sample(1022, 4);
        queue_sample(341, 5);
        queue_sample(0, 6);
        queue_sample(1023, 7);

        for (int i = 0; i < RAND_ITEMS; i++) begin : fill
            int unsigned v;
            case ($urandom_range(3))
                0:       v = $urandom_range(1023);
                1:       v = $urandom_range(1) ? 1023 : 0;
                2:       v = $urandom_range(7);
                default: v = $urandom_range(1023, 1016);
            endcase
            queue_sample(v, $urandom_range(NCH - 1));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_q.size() > 0 || avg_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d averages from %0d samples on %0d channels, window %0d.",
                 n_results, n_accepted, NCH, NWIN);
        $display("Negative steps: %0d, wraps below zero: %0d.", n_neg_steps, n_wraps);
        if (n_errors == 0 && avg_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #400000;
        $display("Timeout: %0d samples accepted, %0d results", n_accepted, n_results);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hdl/mma_pkg.sv
hdl/mma_in_if.sv
hdl/mma_out_if.sv
hdl/mma_ram.sv
hdl/mma_fetch.sv
hdl/mma_update.sv
hdl/multichannel_moving_average.sv
hdl/mma_checker.sv
tb/tb_top.sv
